/* rtl/core/ethst_pkg.sv */
// ----------------------------------------------------------------------------
// ethst_pkg: shared types and constants of the Ethernet event statistics core
// Holds the input and result word layouts, request and disposition codes,
// statistics counter indexes and the frame size limits.
// ----------------------------------------------------------------------------
package ethst_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Request codes.
    localparam logic [2:0] REQ_RX_FRAME = 3'd0;
    localparam logic [2:0] REQ_TX_DONE  = 3'd1;
    localparam logic [2:0] REQ_TX_ABORT = 3'd2;
    localparam logic [2:0] REQ_RX_ABORT = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;

    // Disposition codes.
    localparam logic [3:0] DISP_ACCEPT   = 4'd0;
    localparam logic [3:0] DISP_CRC      = 4'd1;
    localparam logic [3:0] DISP_RUNT     = 4'd2;
    localparam logic [3:0] DISP_TOO_LONG = 4'd3;
    localparam logic [3:0] DISP_UNWANTED = 4'd4;
    localparam logic [3:0] DISP_NO_PROTO = 4'd5;
    localparam logic [3:0] DISP_TX_OK    = 4'd6;
    localparam logic [3:0] DISP_TX_ABORT = 4'd7;
    localparam logic [3:0] DISP_RX_ABORT = 4'd8;
    localparam logic [3:0] DISP_READ     = 4'd9;

    // Statistics counter indexes.
    localparam int NUM_CNT          = 18;
    localparam int CNT_FCS          = 0;
    localparam int CNT_RUNT         = 1;
    localparam int CNT_TOO_LONG     = 2;
    localparam int CNT_BCAST        = 3;
    localparam int CNT_MCAST        = 4;
    localparam int CNT_UNWANTED     = 5;
    localparam int CNT_UNKNOWN_PROTO = 6;
    localparam int CNT_RX_FRAMES    = 7;
    localparam int CNT_DEFERRED     = 8;
    localparam int CNT_COLL_FRAMES  = 9;
    localparam int CNT_SINGLE_COLL  = 10;
    localparam int CNT_MULTI_COLL   = 11;
    localparam int CNT_TX_FRAMES    = 12;
    localparam int CNT_EXC_DEFER    = 13;
    localparam int CNT_EXC_COLL     = 14;
    localparam int CNT_LATE_COLL    = 15;
    localparam int CNT_TX_INTERNAL  = 16;
    localparam int CNT_RX_INTERNAL  = 17;

    // Read selectors beyond the counters.
    localparam logic [4:0] SEL_PKT_PEAK  = 5'd18;
    localparam logic [4:0] SEL_BYTE_PEAK = 5'd19;

    // Frame size limits.
    localparam logic [15:0] FCS_LEN    = 16'd4;
    localparam logic [15:0] HDR_LEN    = 16'd14;
    localparam logic [15:0] MIN_LEN    = 16'd60;
    localparam logic [15:0] MAX_LEN    = 16'd1514;
    localparam logic [15:0] TYPE_LIMIT = 16'h0600;

    // Receive flag bits.
    localparam int RXF_CRC   = 0;
    localparam int RXF_UCAST = 1;
    localparam int RXF_BCAST = 2;
    localparam int RXF_MCAST = 3;
    localparam int RXF_HASH  = 4;

    // Transmit flag bits.
    localparam int TXF_DEFER     = 0;
    localparam int TXF_EXC_DEFER = 1;
    localparam int TXF_MAX_COLL  = 2;
    localparam int TXF_LATE_COLL = 3;

    // Protocol slot register layout.
    localparam int SLOT_IN_USE = 16;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] frame_length;
        logic [4:0]  rx_flags;
        logic [15:0] ether_type;
        logic [7:0]  pending_packets;
        logic [15:0] pending_bytes;
        logic [3:0]  tx_collisions;
        logic [3:0]  tx_flags;
        logic [4:0]  counter_select;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  disposition;
        logic [1:0]  handler_slot;
        logic [10:0] payload_length;
        logic [31:0] counter_value;
    } t_out_item;

    // Classification of one word.
    typedef struct packed {
        logic [3:0]         disposition;
        logic [1:0]         handler_slot;
        logic [10:0]        payload_length;
        logic [NUM_CNT-1:0] bump;
    } t_cls;

    // Update and read request to the counter bank.
    typedef struct packed {
        logic               vld;
        logic               rx_frame;
        logic [NUM_CNT-1:0] bump;
        logic [7:0]         pending_packets;
        logic [15:0]        pending_bytes;
        logic [4:0]         rd_sel;
    } t_upd;

endpackage

/* rtl/core/ethst_classify.sv */
// ----------------------------------------------------------------------------
// ethst_classify: event classification
// Checks a received frame for errors, address class and protocol slot, and
// decodes transmit and abort events into counter bumps and a disposition.
// ----------------------------------------------------------------------------
module ethst_classify #(
    parameter int PROTO_SLOTS = 4
) (
    input  ethst_pkg::t_in_item                               i_item,
    input  logic [PROTO_SLOTS-1:0][ethst_pkg::CFG_DATA_W-1:0] i_slots,
    output ethst_pkg::t_cls                                   o_cls
);

    logic [15:0]            len;
    logic [15:0]            proto;
    logic [15:0]            pay;
    logic [PROTO_SLOTS-1:0] match;
    logic                   found;
    logic [1:0]             slot;
    logic                   addr_ok;

    // Frame length without the frame check sequence; wraps for short frames.
    assign len   = i_item.frame_length - ethst_pkg::FCS_LEN;
    assign pay   = len - ethst_pkg::HDR_LEN;
    assign proto = (i_item.ether_type < ethst_pkg::TYPE_LIMIT) ? 16'd0
                                                                : i_item.ether_type;

    // Protocol slot match; the lowest matching slot wins.
    always_comb begin
        found = 1'b0;
        slot  = 2'd0;
        for (int i = 0; i < PROTO_SLOTS; i++) begin
            match[i] = i_slots[i][ethst_pkg::SLOT_IN_USE] && (i_slots[i][15:0] == proto);
        end
        for (int i = PROTO_SLOTS - 1; i >= 0; i--) begin
            if (match[i]) begin
                found = 1'b1;
                slot  = 2'(i);
            end
        end
    end

    // Disposition and counter bumps for each request type.
    always_comb begin
        o_cls   = '0;
        addr_ok = 1'b0;
        unique case (i_item.req_type)
            ethst_pkg::REQ_RX_FRAME: begin
                priority if (i_item.rx_flags[ethst_pkg::RXF_CRC]) begin
                    o_cls.bump[ethst_pkg::CNT_FCS] = 1'b1;
                    o_cls.disposition = ethst_pkg::DISP_CRC;
                end else if (len < ethst_pkg::MIN_LEN) begin
                    o_cls.bump[ethst_pkg::CNT_RUNT] = 1'b1;
                    o_cls.disposition = ethst_pkg::DISP_RUNT;
                end else if (len > ethst_pkg::MAX_LEN) begin
                    o_cls.bump[ethst_pkg::CNT_TOO_LONG] = 1'b1;
                    o_cls.disposition = ethst_pkg::DISP_TOO_LONG;
                end else if (i_item.rx_flags[ethst_pkg::RXF_UCAST]) begin
                    addr_ok = 1'b1;
                end else if (i_item.rx_flags[ethst_pkg::RXF_BCAST]) begin
                    o_cls.bump[ethst_pkg::CNT_BCAST] = 1'b1;
                    addr_ok = 1'b1;
                end else if (i_item.rx_flags[ethst_pkg::RXF_MCAST] &&
                             i_item.rx_flags[ethst_pkg::RXF_HASH]) begin
                    o_cls.bump[ethst_pkg::CNT_MCAST] = 1'b1;
                    addr_ok = 1'b1;
                end else begin
                    o_cls.bump[ethst_pkg::CNT_UNWANTED] = 1'b1;
                    o_cls.disposition = ethst_pkg::DISP_UNWANTED;
                end

                // A wanted frame is accepted only if a slot handles its protocol.
                if (addr_ok) begin
                    if (found) begin
                        o_cls.bump[ethst_pkg::CNT_RX_FRAMES] = 1'b1;
                        o_cls.disposition    = ethst_pkg::DISP_ACCEPT;
                        o_cls.handler_slot   = slot;
                        o_cls.payload_length = pay[10:0];
                    end else begin
                        o_cls.bump[ethst_pkg::CNT_UNKNOWN_PROTO] = 1'b1;
                        o_cls.disposition = ethst_pkg::DISP_NO_PROTO;
                    end
                end
            end
            ethst_pkg::REQ_TX_DONE: begin
                o_cls.bump[ethst_pkg::CNT_DEFERRED]  = i_item.tx_flags[ethst_pkg::TXF_DEFER];
                o_cls.bump[ethst_pkg::CNT_COLL_FRAMES] = (i_item.tx_collisions != 4'd0);
                o_cls.bump[ethst_pkg::CNT_SINGLE_COLL] = (i_item.tx_collisions == 4'd1);
                o_cls.bump[ethst_pkg::CNT_MULTI_COLL]  = (i_item.tx_collisions > 4'd1);
                o_cls.bump[ethst_pkg::CNT_TX_FRAMES]   = 1'b1;
                o_cls.disposition = ethst_pkg::DISP_TX_OK;
            end
            ethst_pkg::REQ_TX_ABORT: begin
                priority if (i_item.tx_flags[ethst_pkg::TXF_EXC_DEFER]) begin
                    o_cls.bump[ethst_pkg::CNT_EXC_DEFER] = 1'b1;
                end else if (i_item.tx_flags[ethst_pkg::TXF_MAX_COLL]) begin
                    o_cls.bump[ethst_pkg::CNT_EXC_COLL] = 1'b1;
                end else if (i_item.tx_flags[ethst_pkg::TXF_LATE_COLL]) begin
                    o_cls.bump[ethst_pkg::CNT_LATE_COLL] = 1'b1;
                end else begin
                    o_cls.bump[ethst_pkg::CNT_TX_INTERNAL] = 1'b1;
                end
                o_cls.disposition = ethst_pkg::DISP_TX_ABORT;
            end
            ethst_pkg::REQ_RX_ABORT: begin
                o_cls.bump[ethst_pkg::CNT_RX_INTERNAL] = 1'b1;
                o_cls.disposition = ethst_pkg::DISP_RX_ABORT;
            end
            default: begin
                // Counter reads and unused request codes change nothing.
                o_cls.disposition = ethst_pkg::DISP_READ;
            end
        endcase
    end

endmodule

/* rtl/core/ethst_counters.sv */
// ----------------------------------------------------------------------------
// ethst_counters: statistics counter bank
// Holds the wrapping event counters and the receive high-water marks, and
// returns the selected one for a read.
// ----------------------------------------------------------------------------
module ethst_counters #(
    parameter int COUNTER_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ethst_pkg::t_upd   i_upd,
    output logic [31:0]       o_rd_value
);

    localparam int RD_BITS = (COUNTER_BITS < 32) ? COUNTER_BITS : 32;

    logic [COUNTER_BITS-1:0] r_cnt [ethst_pkg::NUM_CNT];
    logic [7:0]              r_pkt_peak;
    logic [15:0]             r_byte_peak;

    // Counters and high-water marks; marks follow every received frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ethst_pkg::NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_pkt_peak  <= '0;
            r_byte_peak <= '0;
        end else if (i_upd.vld) begin
            for (int i = 0; i < ethst_pkg::NUM_CNT; i++) begin
                if (i_upd.bump[i]) begin
                    r_cnt[i] <= r_cnt[i] + {{(COUNTER_BITS-1){1'b0}}, 1'b1};
                end
            end
            if (i_upd.rx_frame && (i_upd.pending_packets > r_pkt_peak)) begin
                r_pkt_peak <= i_upd.pending_packets;
            end
            if (i_upd.rx_frame && (i_upd.pending_bytes > r_byte_peak)) begin
                r_byte_peak <= i_upd.pending_bytes;
            end
        end
    end

    // Read selection; a counter is returned in its low 32 bits.
    always_comb begin
        priority if (i_upd.rd_sel < 5'(ethst_pkg::NUM_CNT)) begin
            o_rd_value = 32'(r_cnt[i_upd.rd_sel][RD_BITS-1:0]);
        end else if (i_upd.rd_sel == ethst_pkg::SEL_PKT_PEAK) begin
            o_rd_value = 32'(r_pkt_peak);
        end else if (i_upd.rd_sel == ethst_pkg::SEL_BYTE_PEAK) begin
            o_rd_value = 32'(r_byte_peak);
        end else begin
            o_rd_value = 32'd0;
        end
    end

`ifndef ASSERT_OFF
    // High-water marks never fall outside reset.
    a_pkt_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_pkt_peak >= $past(r_pkt_peak))
        else $error("packet high-water mark decreased");

    a_byte_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_byte_peak >= $past(r_byte_peak))
        else $error("byte high-water mark decreased");

    // Receive aborts always move their counter by one.
    a_rx_abort_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_upd.vld) && $past(i_upd.bump[ethst_pkg::CNT_RX_INTERNAL])
        |-> r_cnt[ethst_pkg::CNT_RX_INTERNAL] ==
            $past(r_cnt[ethst_pkg::CNT_RX_INTERNAL]) + {{(COUNTER_BITS-1){1'b0}}, 1'b1})
        else $error("receive abort counter did not advance");
`endif

endmodule

/* rtl/core/ethernet_rx_tx_event_stats_core.sv */
// ----------------------------------------------------------------------------
// ethernet_rx_tx_event_stats_core: Ethernet MAC event statistics
// Flow: an accepted word is classified in the input register, and its result
// is then registered in the result register, where it waits until it is
// taken.
// Throughput: one word per cycle; the input stage advances whenever the
// result register is empty or being taken in the same cycle.
// Reset: synchronous, active low; empties both stages and clears all
// counters, the high-water marks and the protocol slot registers at once.
// ----------------------------------------------------------------------------
module ethernet_rx_tx_event_stats_core #(
    parameter int PROTO_SLOTS  = 4,
    parameter int COUNTER_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_vld,
    output logic                              o_in_stall,
    input  ethst_pkg::t_in_item               i_in_data,
    output logic                              o_out_vld,
    input  logic                              i_out_stall,
    output ethst_pkg::t_out_item              o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ethst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ethst_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic [PROTO_SLOTS-1:0][ethst_pkg::CFG_DATA_W-1:0] r_slot;
    logic                 r_in_vld;
    ethst_pkg::t_in_item  r_in;
    logic                 r_out_vld;
    ethst_pkg::t_out_item r_out;
    ethst_pkg::t_out_item n_out;
    ethst_pkg::t_cls      cls;
    ethst_pkg::t_upd      upd;
    logic [31:0]          rd_value;
    logic                 advance;
    logic                 in_acc;

    // Handshake: the input word moves on when the result register frees up.
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_acc     = i_in_vld && !o_in_stall;
    assign o_out_vld  = r_out_vld;
    assign o_out_data = r_out;

    // Protocol slot registers; indexes beyond the slots are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_cfg_we) begin
            for (int i = 0; i < PROTO_SLOTS; i++) begin
                if (32'(i_cfg_index) == i) begin
                    r_slot[i] <= i_cfg_wdata;
                end
            end
        end
    end

    ethst_classify #(
        .PROTO_SLOTS(PROTO_SLOTS)
    ) u_classify (
        .i_item (r_in),
        .i_slots(r_slot),
        .o_cls  (cls)
    );

    // Counter update request for the word leaving the input register.
    always_comb begin
        upd.vld             = advance;
        upd.rx_frame        = (r_in.req_type == ethst_pkg::REQ_RX_FRAME);
        upd.bump            = cls.bump;
        upd.pending_packets = r_in.pending_packets;
        upd.pending_bytes   = r_in.pending_bytes;
        upd.rd_sel          = r_in.counter_select;
    end

    ethst_counters #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_counters (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .o_rd_value(rd_value)
    );

    // Result word.
    always_comb begin
        n_out.disposition    = cls.disposition;
        n_out.handler_slot   = cls.handler_slot;
        n_out.payload_length = cls.payload_length;
        n_out.counter_value  = (cls.disposition == ethst_pkg::DISP_READ) ? rd_value : 32'd0;
    end

    // Input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // Stalling the input only happens with both stages full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld && r_out_vld && i_out_stall)
        else $error("input stalled with a free stage");

    // Accepted frames carry a payload within the legal range.
    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_vld && (o_out_data.disposition == ethst_pkg::DISP_ACCEPT)
        |-> (o_out_data.payload_length >= 11'd46) && (o_out_data.payload_length <= 11'd1500))
        else $error("accepted frame with bad payload length");

    // Anything not accepted reports no slot and no payload.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_vld && (o_out_data.disposition != ethst_pkg::DISP_ACCEPT)
        |-> (o_out_data.handler_slot == 2'd0) && (o_out_data.payload_length == 11'd0))
        else $error("slot or payload set on a non-accepted result");
`endif

endmodule

/* test/ethernet_rx_tx_event_stats_core_test.sv */
// ----------------------------------------------------------------------------
// ethernet_rx_tx_event_stats_core_test: self-checking bench for the MAC event
// statistics core.
// A short table of directed words covers the frame length limits, CRC, address
// and protocol-slot cases, every transmit flag and the counter reads. Random
// words follow under several protocol slot settings. Every word is run through
// a local copy of the counters and slots, and each result word is compared
// field by field with the oldest pending expectation. Both handshakes idle at
// random, and once the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module ethernet_rx_tx_event_stats_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ethst_pkg::*;

    localparam int NUM_SLOTS     = 4;
    localparam int RST_CYCLES    = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 120;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_WORDS   = 250;
    localparam int NUM_DIRECTED  = 27;

    // Request codes the core does not define; they must act as reads.
    localparam logic [2:0] REQ_SPARE    = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    localparam logic [4:0] SEL_TOP      = 5'd31;

    // Single-bit flag masks.
    localparam logic [4:0] FL_CRC   = 5'b1 << RXF_CRC;
    localparam logic [4:0] FL_UCAST = 5'b1 << RXF_UCAST;
    localparam logic [4:0] FL_BCAST = 5'b1 << RXF_BCAST;
    localparam logic [4:0] FL_MCAST = 5'b1 << RXF_MCAST;
    localparam logic [4:0] FL_HASH  = 5'b1 << RXF_HASH;
    localparam logic [3:0] TF_DEFER     = 4'b1 << TXF_DEFER;
    localparam logic [3:0] TF_EXC_DEFER = 4'b1 << TXF_EXC_DEFER;
    localparam logic [3:0] TF_MAX_COLL  = 4'b1 << TXF_MAX_COLL;
    localparam logic [3:0] TF_LATE_COLL = 4'b1 << TXF_LATE_COLL;

    localparam t_out_item NO_RES = '0;

    typedef struct packed {
        logic      fixed;
        t_out_item want;
    } t_pin;

    typedef struct packed {
        t_in_item  w;
        logic      fixed;
        t_out_item want;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_vld    = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_vld;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Local copy of the core state.
    logic [31:0]           stat_cnt [NUM_CNT] = '{default: '0};
    logic [7:0]            pkt_peak  = '0;
    logic [15:0]           byte_peak = '0;
    logic [CFG_DATA_W-1:0] slot_reg [NUM_SLOTS] = '{default: '0};

    t_out_item result_q [$];
    t_pin      pinned_q [$];
    t_dir_row  dir_tab [NUM_DIRECTED];

    int  errors      = 0;
    int  n_events    = 0;
    int  n_frames    = 0;
    int  n_accepted  = 0;
    int  n_reads     = 0;
    bit  tx_calm     = 1'b0;
    bit  rx_calm     = 1'b0;
    bit  squeeze_req = 1'b0;

    ethernet_rx_tx_event_stats_core #(
        .PROTO_SLOTS  (NUM_SLOTS),
        .COUNTER_BITS (32)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (i_in_vld),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_vld   (o_out_vld),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Counter bump with 32-bit wrap.
    function automatic void count_up(input int idx);
        stat_cnt[idx] = stat_cnt[idx] + 32'd1;
    endfunction

    // Classifies one word against the local state and updates that state.
    function automatic t_out_item classify_event(input t_in_item w);
        t_out_item   r;
        logic [15:0] len;
        logic [15:0] proto;
        logic [15:0] pay;
        logic        ok;
        logic        found;
        int          i;
        r = '0;
        r.disposition = DISP_READ;
        ok = 1'b0;
        found = 1'b0;
        case (w.req_type)
            REQ_RX_FRAME: begin
                len = w.frame_length - FCS_LEN;
                if (w.pending_packets > pkt_peak) pkt_peak = w.pending_packets;
                if (w.pending_bytes > byte_peak) byte_peak = w.pending_bytes;
                // Error checks come first, then the address class.
                if (w.rx_flags[RXF_CRC]) begin
                    count_up(CNT_FCS);
                    r.disposition = DISP_CRC;
                end else if (len < MIN_LEN) begin
                    count_up(CNT_RUNT);
                    r.disposition = DISP_RUNT;
                end else if (len > MAX_LEN) begin
                    count_up(CNT_TOO_LONG);
                    r.disposition = DISP_TOO_LONG;
                end else if (w.rx_flags[RXF_UCAST]) begin
                    ok = 1'b1;
                end else if (w.rx_flags[RXF_BCAST]) begin
                    count_up(CNT_BCAST);
                    ok = 1'b1;
                end else if (w.rx_flags[RXF_MCAST] && w.rx_flags[RXF_HASH]) begin
                    count_up(CNT_MCAST);
                    ok = 1'b1;
                end else begin
                    count_up(CNT_UNWANTED);
                    r.disposition = DISP_UNWANTED;
                end
                // Lowest in-use slot with the matching protocol wins.
                if (ok) begin
                    proto = (w.ether_type < TYPE_LIMIT) ? 16'd0 : w.ether_type;
                    for (i = 0; i < NUM_SLOTS && !found; i++) begin
                        if (slot_reg[i][SLOT_IN_USE] && slot_reg[i][15:0] == proto) begin
                            found = 1'b1;
                            r.handler_slot = i[1:0];
                        end
                    end
                    if (!found) begin
                        count_up(CNT_UNKNOWN_PROTO);
                        r.disposition = DISP_NO_PROTO;
                    end else begin
                        count_up(CNT_RX_FRAMES);
                        r.disposition = DISP_ACCEPT;
                        pay = len - HDR_LEN;
                        r.payload_length = pay[10:0];
                    end
                end
            end
            REQ_TX_DONE: begin
                if (w.tx_flags[TXF_DEFER]) count_up(CNT_DEFERRED);
                if (w.tx_collisions != 4'd0) begin
                    count_up(CNT_COLL_FRAMES);
                    count_up(w.tx_collisions == 4'd1 ? CNT_SINGLE_COLL : CNT_MULTI_COLL);
                end
                count_up(CNT_TX_FRAMES);
                r.disposition = DISP_TX_OK;
            end
            REQ_TX_ABORT: begin
                if (w.tx_flags[TXF_EXC_DEFER]) count_up(CNT_EXC_DEFER);
                else if (w.tx_flags[TXF_MAX_COLL]) count_up(CNT_EXC_COLL);
                else if (w.tx_flags[TXF_LATE_COLL]) count_up(CNT_LATE_COLL);
                else count_up(CNT_TX_INTERNAL);
                r.disposition = DISP_TX_ABORT;
            end
            REQ_RX_ABORT: begin
                count_up(CNT_RX_INTERNAL);
                r.disposition = DISP_RX_ABORT;
            end
            default: begin
                // Reads, and any undefined request, return a counter.
                if (w.counter_select < NUM_CNT) r.counter_value = stat_cnt[w.counter_select];
                else if (w.counter_select == SEL_PKT_PEAK) r.counter_value = {24'd0, pkt_peak};
                else if (w.counter_select == SEL_BYTE_PEAK) r.counter_value = {16'd0, byte_peak};
            end
        endcase
        return r;
    endfunction

    // Word builders for the directed table.
    function automatic t_in_item rx(input logic [15:0] len, input logic [4:0] flags,
                                    input logic [15:0] etype, input logic [7:0] pp,
                                    input logic [15:0] pb);
        t_in_item w;
        w = '0;
        w.req_type        = REQ_RX_FRAME;
        w.frame_length    = len;
        w.rx_flags        = flags;
        w.ether_type      = etype;
        w.pending_packets = pp;
        w.pending_bytes   = pb;
        return w;
    endfunction

    function automatic t_in_item tx(input logic [2:0] req, input logic [3:0] coll,
                                    input logic [3:0] flags);
        t_in_item w;
        w = '0;
        w.req_type      = req;
        w.tx_collisions = coll;
        w.tx_flags      = flags;
        return w;
    endfunction

    function automatic t_in_item rd(input logic [2:0] req, input logic [4:0] sel);
        t_in_item w;
        w = '0;
        w.req_type       = req;
        w.counter_select = sel;
        return w;
    endfunction

    function automatic t_out_item res(input logic [3:0] d, input logic [1:0] s,
                                      input logic [10:0] p, input logic [31:0] v);
        t_out_item r;
        r.disposition    = d;
        r.handler_slot   = s;
        r.payload_length = p;
        r.counter_value  = v;
        return r;
    endfunction

    // Protocol numbers that land on the interesting compare cases.
    function automatic logic [15:0] pick_proto();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h0800;
            2:       return 16'h86DD;
            3:       return 16'h0806;
            4:       return TYPE_LIMIT;
            5:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random word: mostly frames, weighted toward the limits and slot-hitting types.
    function automatic t_in_item random_event();
        logic [95:0] bits;
        t_in_item    w;
        int          r;
        int          k;
        logic [15:0] p;
        bits = {$urandom, $urandom, $urandom};
        w = bits[$bits(t_in_item)-1:0];
        r = $urandom_range(0, 99);
        if (r < 55) begin
            w.req_type = REQ_RX_FRAME;
            case ($urandom_range(0, 19))
                0:       w.frame_length = 16'($urandom_range(0, FCS_LEN - 1));
                1:       w.frame_length = 16'($urandom_range(MIN_LEN + FCS_LEN - 2,
                                                             MIN_LEN + FCS_LEN + 1));
                2:       w.frame_length = 16'($urandom_range(MAX_LEN + FCS_LEN - 1,
                                                             MAX_LEN + FCS_LEN + 2));
                3:       w.frame_length = 16'hFFFF;
                4:       ;
                default: w.frame_length = 16'($urandom_range(MIN_LEN + FCS_LEN,
                                                             MAX_LEN + FCS_LEN));
            endcase
            if ($urandom_range(0, 3) != 0) w.rx_flags[RXF_CRC] = 1'b0;
            r = $urandom_range(0, 9);
            if (r < 4) begin
                k = $urandom_range(0, NUM_SLOTS - 1);
                p = slot_reg[k][15:0];
                w.ether_type = (p == 16'd0) ? 16'($urandom_range(0, TYPE_LIMIT - 1)) : p;
            end else if (r < 6) begin
                w.ether_type = 16'($urandom_range(0, TYPE_LIMIT - 1));
            end else if (r < 8) begin
                w.ether_type = pick_proto();
            end
        end else if (r < 70) begin
            w.req_type = REQ_TX_DONE;
        end else if (r < 80) begin
            w.req_type = REQ_TX_ABORT;
        end else if (r < 85) begin
            w.req_type = REQ_RX_ABORT;
        end else if (r < 96) begin
            w.req_type = REQ_READ;
            if ($urandom_range(0, 3) != 0) begin
                w.counter_select = 5'($urandom_range(0, SEL_BYTE_PEAK));
            end
        end else begin
            w.req_type = 3'($urandom_range(REQ_SPARE, REQ_SPARE_HI));
        end
        return w;
    endfunction

    function automatic int next_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Writes all protocol slots; only called while the core is idle.
    task automatic load_slots(input logic [NUM_SLOTS-1:0][CFG_DATA_W-1:0] vals);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[CFG_IDX_W-1:0];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            slot_reg[i] = vals[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offers one word after a random gap and waits until it is taken.
    task automatic drive_word(input t_in_item w, input logic fixed, input t_out_item want);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_in_vld <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pinned_q.push_back({fixed, want});
        i_in_vld  <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stops offering and waits for every pending result.
    task automatic settle();
        i_in_vld <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side stall pattern, with one long hold when asked.
    initial begin
        @(posedge i_clk);
        forever begin
            if (squeeze_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                squeeze_req = 1'b0;
            end else if (rx_calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 15) == 0) repeat ($urandom_range(15, 50)) @(posedge i_clk);
                else repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    // Result checking and prediction of each accepted word.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        t_pin      pin;
        if (i_rst_n) begin
            if (o_out_vld && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result word with no expectation pending");
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (o_out_data.disposition !== want.disposition) begin
                        $error("disposition: expected %0d, got %0d",
                               want.disposition, o_out_data.disposition);
                        errors++;
                    end
                    if (o_out_data.handler_slot !== want.handler_slot) begin
                        $error("handler_slot: expected %0d, got %0d",
                               want.handler_slot, o_out_data.handler_slot);
                        errors++;
                    end
                    if (o_out_data.payload_length !== want.payload_length) begin
                        $error("payload_length: expected %0d, got %0d",
                               want.payload_length, o_out_data.payload_length);
                        errors++;
                    end
                    if (o_out_data.counter_value !== want.counter_value) begin
                        $error("counter_value: expected %0d, got %0d",
                               want.counter_value, o_out_data.counter_value);
                        errors++;
                    end
                end
            end
            if (i_in_vld && !o_in_stall) begin
                pin  = pinned_q.pop_front();
                pred = classify_event(i_in_data);
                result_q.push_back(pin.fixed ? pin.want : pred);
                n_events++;
                if (i_in_data.req_type == REQ_RX_FRAME) n_frames++;
                if (i_in_data.req_type == REQ_RX_FRAME && pred.disposition == DISP_ACCEPT)
                    n_accepted++;
                if (pred.disposition == DISP_READ) n_reads++;
            end
        end
    end

    // Stimulus.
    initial begin
        logic [NUM_SLOTS-1:0][CFG_DATA_W-1:0] slots;
        // Slot 0 takes 802.2 frames; slot 3 duplicates slot 1 and must lose.
        dir_tab = '{
            '{rd(REQ_READ, 5'(CNT_FCS)), 1'b1, res(DISP_READ, 0, 0, 0)},
            '{rd(REQ_READ, SEL_BYTE_PEAK), 1'b1, res(DISP_READ, 0, 0, 0)},
            '{rx(16'd64, FL_CRC, 16'h0800, 0, 0), 1'b1, res(DISP_CRC, 0, 0, 0)},
            '{rx(16'd0, FL_UCAST, 16'h0800, 1, 1), 1'b1, res(DISP_TOO_LONG, 0, 0, 0)},
            '{rx(16'd3, FL_UCAST, 16'h0800, 0, 0), 1'b1, res(DISP_TOO_LONG, 0, 0, 0)},
            '{rx(16'd4, FL_UCAST, 16'h0800, 0, 0), 1'b1, res(DISP_RUNT, 0, 0, 0)},
            '{rx(16'd63, FL_UCAST, 16'h0800, 0, 0), 1'b1, res(DISP_RUNT, 0, 0, 0)},
            '{rx(16'd64, FL_UCAST, 16'h0800, 3, 200), 1'b1, res(DISP_ACCEPT, 1, 46, 0)},
            '{rx(16'd1518, FL_UCAST, 16'h05FF, 8'hFF, 16'hFFFF), 1'b1,
              res(DISP_ACCEPT, 0, 1500, 0)},
            '{rx(16'd1519, FL_UCAST, 16'h0800, 0, 0), 1'b1, res(DISP_TOO_LONG, 0, 0, 0)},
            '{rx(16'hFFFF, 5'h1F, 16'hFFFF, 0, 0), 1'b1, res(DISP_CRC, 0, 0, 0)},
            '{rx(16'd100, FL_BCAST, 16'h86DD, 0, 0), 1'b1, res(DISP_ACCEPT, 2, 82, 0)},
            '{rx(16'd100, FL_MCAST, 16'h0800, 0, 0), 1'b1, res(DISP_UNWANTED, 0, 0, 0)},
            '{rx(16'd200, FL_MCAST | FL_HASH, 16'h1234, 0, 0), 1'b0, NO_RES},
            '{rx(16'd200, 5'd0, 16'h0800, 0, 0), 1'b1, res(DISP_UNWANTED, 0, 0, 0)},
            '{rx(16'd200, FL_UCAST | FL_BCAST, TYPE_LIMIT, 0, 0), 1'b0, NO_RES},
            '{tx(REQ_TX_DONE, 4'd0, 4'd0), 1'b1, res(DISP_TX_OK, 0, 0, 0)},
            '{tx(REQ_TX_DONE, 4'd1, TF_DEFER), 1'b1, res(DISP_TX_OK, 0, 0, 0)},
            '{tx(REQ_TX_DONE, 4'hF, 4'hF), 1'b1, res(DISP_TX_OK, 0, 0, 0)},
            '{tx(REQ_TX_ABORT, 4'd0, TF_EXC_DEFER), 1'b1, res(DISP_TX_ABORT, 0, 0, 0)},
            '{tx(REQ_TX_ABORT, 4'd0, TF_MAX_COLL), 1'b1, res(DISP_TX_ABORT, 0, 0, 0)},
            '{tx(REQ_TX_ABORT, 4'd0, TF_LATE_COLL), 1'b1, res(DISP_TX_ABORT, 0, 0, 0)},
            '{tx(REQ_TX_ABORT, 4'd0, 4'd0), 1'b1, res(DISP_TX_ABORT, 0, 0, 0)},
            '{tx(REQ_RX_ABORT, 4'd0, 4'd0), 1'b1, res(DISP_RX_ABORT, 0, 0, 0)},
            '{rd(REQ_READ, 5'(CNT_RX_FRAMES)), 1'b0, NO_RES},
            '{rd(REQ_SPARE, SEL_PKT_PEAK), 1'b0, NO_RES},
            '{rd(REQ_SPARE_HI, SEL_TOP), 1'b1, res(DISP_READ, 0, 0, 0)}
        };

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        load_slots({17'h1_0800, 17'h1_86DD, 17'h1_0800, 17'h1_0000});
        foreach (dir_tab[k]) drive_word(dir_tab[k].w, dir_tab[k].fixed, dir_tab[k].want);
        settle();

        // Random phases; the first two use the extreme slot settings.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (ph == 0) slots[i] = '1;
                else if (ph == 1) slots[i] = '0;
                else slots[i] = {1'($urandom_range(0, 3) != 0), pick_proto()};
            end
            load_slots(slots);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Each phase opens with a stretch of back-to-back traffic.
                tx_calm = (n < 40);
                rx_calm = (n < 40);
                // One long result hold while words keep coming.
                if (ph == 2 && n == 100) squeeze_req = 1'b1;
                if (ph == 2 && n >= 100 && n < 160) tx_calm = 1'b1;
                drive_word(random_event(), 1'b0, NO_RES);
            end
            settle();
        end

        if (result_q.size() != 0) begin
            $error("%0d expected results never arrived", result_q.size());
            errors++;
        end
        $display("Checked %0d events: %0d received frames (%0d accepted), %0d reads.",
                 n_events, n_frames, n_accepted, n_reads);
        $display("Ran %0d slot settings with random gaps, stalls and one long output hold.",
                 NUM_PHASES + 1);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
